/* hdl/tfm_pkg.sv */
// Shared types, widths and constants for the temporal frame mean block.
// Used by tfm_front, tfm_back and temporal_frame_mean_core; depends on nothing.
`timescale 1ns / 1ps

package tfm_pkg;

    localparam int SAMPLE_W    = 8;
    localparam int FE_W        = 15;
    localparam int WL_W        = 5;
    localparam int N_W         = 5;
    localparam int SUM_W       = 13;
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 18;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 3;

    typedef enum logic
    {
        REG_FRAME_ELEMENTS = 1'b0,
        REG_WINDOW_LENGTH  = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic           first;
        logic           steady;
        logic           last;
        logic [N_W-1:0] n;
    } ctrl_t;

    // Reciprocal of n scaled by 2**RECIP_SHIFT and rounded up; exact floor for sum*n < 2**18.
    function automatic logic [RECIP_W-1:0] recip(input logic [N_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            5'd1:    r = 19'd262144;
            5'd2:    r = 19'd131072;
            5'd3:    r = 19'd87382;
            5'd4:    r = 19'd65536;
            5'd5:    r = 19'd52429;
            5'd6:    r = 19'd43691;
            5'd7:    r = 19'd37450;
            5'd8:    r = 19'd32768;
            5'd9:    r = 19'd29128;
            5'd10:   r = 19'd26215;
            5'd11:   r = 19'd23832;
            5'd12:   r = 19'd21846;
            5'd13:   r = 19'd20165;
            5'd14:   r = 19'd18725;
            5'd15:   r = 19'd17477;
            5'd16:   r = 19'd16384;
            5'd17:   r = 19'd15421;
            5'd18:   r = 19'd14564;
            5'd19:   r = 19'd13798;
            5'd20:   r = 19'd13108;
            5'd21:   r = 19'd12484;
            5'd22:   r = 19'd11916;
            5'd23:   r = 19'd11398;
            5'd24:   r = 19'd10923;
            5'd25:   r = 19'd10486;
            5'd26:   r = 19'd10083;
            5'd27:   r = 19'd9710;
            5'd28:   r = 19'd9363;
            5'd29:   r = 19'd9040;
            5'd30:   r = 19'd8739;
            5'd31:   r = 19'd8457;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

/* hdl/tfm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module tfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/tfm_fifo.sv */
// Small register-based first-in first-out queue.
// Depends on nothing.
`timescale 1ns / 1ps

module tfm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             wdata,
    output logic                         full,
    input  logic                         pop,
    output logic [WIDTH-1:0]             rdata,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_ok;
    logic             pop_ok;

    assign full    = (32'(count_reg) == DEPTH);
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop_ok)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push_ok && !pop_ok)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* hdl/tfm_front.sv */
// Front end: configuration registers, frame position and window bookkeeping.
// Classifies each accepted sample and hands it to the back end queue. Uses tfm_pkg.
`timescale 1ns / 1ps

module tfm_front #(
    parameter int MAX_WINDOW   = 16,
    parameter int MAX_ELEMENTS = 16384
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tfm_pkg::APB_AW-1:0]          paddr,
    input  logic [tfm_pkg::APB_DW-1:0]          pwdata,
    output logic [tfm_pkg::APB_DW-1:0]          prdata,
    output logic                                pready,
    input  logic                                push,
    output logic                                full,
    input  logic [tfm_pkg::SAMPLE_W-1:0]        sample,
    input  logic                                q_full,
    output logic                                q_push,
    output logic [tfm_pkg::SAMPLE_W-1:0]        q_sample,
    output logic [(MAX_ELEMENTS > 1 ? $clog2(MAX_ELEMENTS) : 1)-1:0] q_pos,
    output logic [(MAX_WINDOW > 1 ? $clog2(MAX_WINDOW) : 1)-1:0]     q_slot,
    output tfm_pkg::ctrl_t                      q_ctrl
);

    localparam int POS_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FE_W   = tfm_pkg::FE_W;
    localparam int WL_W   = tfm_pkg::WL_W;
    localparam int N_W    = tfm_pkg::N_W;

    logic [FE_W-1:0]   fe_reg, fe_next;
    logic [WL_W-1:0]   wl_reg, wl_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [N_W-1:0]    held_reg, held_next;
    logic [SLOT_W-1:0] oldest_reg, oldest_next;
    logic              cfg_wr;
    logic              accept;
    logic              steady;
    logic              last;
    logic [FE_W-1:0]   fe_wr;
    logic [WL_W-1:0]   wl_wr;
    tfm_pkg::reg_idx_t idx;

    assign pready = 1'b1;
    assign idx    = tfm_pkg::reg_idx_t'(paddr[2]);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign full   = q_full;
    assign accept = push && !q_full;
    assign steady = (held_reg >= N_W'(wl_reg));
    assign last   = (32'(pos_reg) + 32'd1 >= 32'(fe_reg));

    always_comb
    begin
        case (idx)
            tfm_pkg::REG_FRAME_ELEMENTS: prdata = tfm_pkg::APB_DW'(fe_reg);
            tfm_pkg::REG_WINDOW_LENGTH:  prdata = tfm_pkg::APB_DW'(wl_reg);
            default:                     prdata = '0;
        endcase
    end

    always_comb
    begin
        fe_wr = pwdata[FE_W-1:0];
        if (fe_wr == '0)
        begin
            fe_wr = FE_W'(1);
        end
        else if (32'(fe_wr) > MAX_ELEMENTS)
        begin
            fe_wr = FE_W'(MAX_ELEMENTS);
        end
        wl_wr = pwdata[WL_W-1:0];
        if (wl_wr == '0)
        begin
            wl_wr = WL_W'(1);
        end
        else if (32'(wl_wr) > MAX_WINDOW)
        begin
            wl_wr = WL_W'(MAX_WINDOW);
        end
    end

    always_comb
    begin
        fe_next     = fe_reg;
        wl_next     = wl_reg;
        pos_next    = pos_reg;
        held_next   = held_reg;
        oldest_next = oldest_reg;
        if (cfg_wr)
        begin
            case (idx)
                tfm_pkg::REG_FRAME_ELEMENTS: fe_next = fe_wr;
                tfm_pkg::REG_WINDOW_LENGTH:  wl_next = wl_wr;
                default:                     fe_next = fe_reg;
            endcase
            pos_next    = '0;
            held_next   = '0;
            oldest_next = '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                pos_next = '0;
                if (!steady)
                begin
                    held_next = N_W'(held_reg + 1'b1);
                end
                else if (32'(oldest_reg) + 32'd1 >= 32'(wl_reg))
                begin
                    oldest_next = '0;
                end
                else
                begin
                    oldest_next = SLOT_W'(oldest_reg + 1'b1);
                end
            end
            else
            begin
                pos_next = POS_W'(pos_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fe_reg     <= FE_W'(1);
            wl_reg     <= WL_W'(1);
            pos_reg    <= '0;
            held_reg   <= '0;
            oldest_reg <= '0;
        end
        else
        begin
            fe_reg     <= fe_next;
            wl_reg     <= wl_next;
            pos_reg    <= pos_next;
            held_reg   <= held_next;
            oldest_reg <= oldest_next;
        end
    end

    assign q_push        = accept;
    assign q_sample      = sample;
    assign q_pos         = pos_reg;
    assign q_slot        = steady ? oldest_reg : SLOT_W'(held_reg);
    assign q_ctrl.first  = (held_reg == '0);
    assign q_ctrl.steady = steady;
    assign q_ctrl.last   = last;
    assign q_ctrl.n      = steady ? N_W'(wl_reg) : N_W'(held_reg + 1'b1);

endmodule

/* hdl/tfm_back.sv */
// Back end: history and running-sum memories, rounded division and result queue.
// Uses tfm_pkg, tfm_ram and tfm_fifo.
`timescale 1ns / 1ps

module tfm_back #(
    parameter int MAX_WINDOW   = 16,
    parameter int MAX_ELEMENTS = 16384
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    output logic                                q_pop,
    input  logic [tfm_pkg::SAMPLE_W-1:0]        q_sample,
    input  logic [(MAX_ELEMENTS > 1 ? $clog2(MAX_ELEMENTS) : 1)-1:0] q_pos,
    input  logic [(MAX_WINDOW > 1 ? $clog2(MAX_WINDOW) : 1)-1:0]     q_slot,
    input  tfm_pkg::ctrl_t                      q_ctrl,
    output logic                                empty,
    input  logic                                pop,
    output logic [tfm_pkg::SAMPLE_W-1:0]        mean,
    output logic                                frame_end
);

    localparam int POS_W   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int HDEPTH  = MAX_WINDOW * MAX_ELEMENTS;
    localparam int HA_W    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
    localparam int SW      = tfm_pkg::SAMPLE_W;
    localparam int SUM_W   = tfm_pkg::SUM_W;
    localparam int N_W     = tfm_pkg::N_W;
    localparam int PROD_W  = SUM_W + tfm_pkg::RECIP_W;
    localparam int ODEPTH  = 8;
    localparam int OCNT_W  = $clog2(ODEPTH + 1);

    logic [HA_W-1:0]   haddr_in;
    logic [SUM_W-1:0]  sum_rdata;
    logic [SW-1:0]     hist_rdata;
    logic [OCNT_W-1:0] ocount;
    logic              ofull;
    logic [SW:0]       orow;
    logic [1:0]        inflight;

    logic              b1v_reg, b2v_reg, b3v_reg;
    logic [SW-1:0]     b1_sample_reg;
    logic [POS_W-1:0]  b1_pos_reg;
    logic [HA_W-1:0]   b1_haddr_reg;
    tfm_pkg::ctrl_t    b1_ctrl_reg;

    logic              fwd_v_reg;
    logic [POS_W-1:0]  fwd_pos_reg;
    logic [SUM_W-1:0]  fwd_sum_reg;
    logic [HA_W-1:0]   fwd_haddr_reg;
    logic [SW-1:0]     fwd_hval_reg;

    logic [SUM_W-1:0]  old_sum;
    logic [SW-1:0]     old_h;
    logic [SUM_W-1:0]  new_sum;

    logic [SUM_W-1:0]  sum2_reg;
    logic [N_W-1:0]    n2_reg;
    logic              last2_reg;
    logic [PROD_W-1:0] prod;

    logic [SUM_W-1:0]  q3_reg;
    logic [SUM_W-1:0]  sum3_reg;
    logic [N_W-1:0]    n3_reg;
    logic              last3_reg;
    logic [SUM_W+N_W-1:0] qn;
    logic [SUM_W-1:0]  rem;
    logic [N_W:0]      rem2;
    logic              round_up;
    logic [SW-1:0]     mean3;

    assign inflight = 2'(b1v_reg) + 2'(b2v_reg) + 2'(b3v_reg);
    assign q_pop    = !q_empty && (32'(ocount) + 32'(inflight) < ODEPTH);
    assign haddr_in = HA_W'(32'(q_slot) * MAX_ELEMENTS + 32'(q_pos));

    tfm_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_sum_ram (
        .clk   (clk),
        .we    (b1v_reg),
        .waddr (b1_pos_reg),
        .wdata (new_sum),
        .re    (q_pop),
        .raddr (q_pos),
        .rdata (sum_rdata)
    );

    tfm_ram #(
        .WIDTH (SW),
        .DEPTH (HDEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (b1v_reg),
        .waddr (b1_haddr_reg),
        .wdata (b1_sample_reg),
        .re    (q_pop),
        .raddr (haddr_in),
        .rdata (hist_rdata)
    );

    // The write made on the edge that captured this read is not yet in the read data.
    always_comb
    begin
        old_sum = (fwd_v_reg && fwd_pos_reg == b1_pos_reg) ? fwd_sum_reg : sum_rdata;
        old_h   = (fwd_v_reg && fwd_haddr_reg == b1_haddr_reg) ? fwd_hval_reg : hist_rdata;
        if (b1_ctrl_reg.first)
        begin
            new_sum = SUM_W'(b1_sample_reg);
        end
        else if (b1_ctrl_reg.steady)
        begin
            new_sum = SUM_W'(old_sum - SUM_W'(old_h) + SUM_W'(b1_sample_reg));
        end
        else
        begin
            new_sum = SUM_W'(old_sum + SUM_W'(b1_sample_reg));
        end
    end

    assign prod = PROD_W'(sum2_reg) * PROD_W'(tfm_pkg::recip(n2_reg));

    always_comb
    begin
        qn       = (SUM_W+N_W)'(q3_reg) * (SUM_W+N_W)'(n3_reg);
        rem      = SUM_W'(sum3_reg - qn[SUM_W-1:0]);
        rem2     = {rem[N_W-1:0], 1'b0};
        round_up = (rem2 > {1'b0, n3_reg}) || ((rem2 == {1'b0, n3_reg}) && q3_reg[0]);
        mean3    = SW'(q3_reg[SW-1:0] + SW'(round_up));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1v_reg   <= 1'b0;
            b2v_reg   <= 1'b0;
            b3v_reg   <= 1'b0;
            fwd_v_reg <= 1'b0;
        end
        else
        begin
            b1v_reg   <= q_pop;
            b2v_reg   <= b1v_reg;
            b3v_reg   <= b2v_reg;
            fwd_v_reg <= b1v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_sample_reg <= q_sample;
        b1_pos_reg    <= q_pos;
        b1_haddr_reg  <= haddr_in;
        b1_ctrl_reg   <= q_ctrl;
        fwd_pos_reg   <= b1_pos_reg;
        fwd_sum_reg   <= new_sum;
        fwd_haddr_reg <= b1_haddr_reg;
        fwd_hval_reg  <= b1_sample_reg;
        sum2_reg      <= new_sum;
        n2_reg        <= b1_ctrl_reg.n;
        last2_reg     <= b1_ctrl_reg.last;
        q3_reg        <= prod[tfm_pkg::RECIP_SHIFT +: SUM_W];
        sum3_reg      <= sum2_reg;
        n3_reg        <= n2_reg;
        last3_reg     <= last2_reg;
    end

    tfm_fifo #(
        .WIDTH (SW + 1),
        .DEPTH (ODEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (b3v_reg),
        .wdata ({last3_reg, mean3}),
        .full  (ofull),
        .pop   (pop),
        .rdata (orow),
        .empty (empty),
        .count (ocount)
    );

    assign mean      = orow[SW-1:0];
    assign frame_end = orow[SW] & ~ofull | orow[SW] & ofull;

endmodule

/* hdl/temporal_frame_mean_core.sv */
// Top level of the temporal frame mean block: front end, item queue and back end.
// Uses tfm_pkg, tfm_front, tfm_fifo and tfm_back.
//
//   Channel   Handshake                          Payload
//   config    psel, penable, pwrite, pready      paddr, pwdata, prdata
//   input     push / full                        sample
//   result    empty / pop                        mean, frame_end
//
// One beat is accepted per clock while full is low. Each beat passes through the item
// queue, then the memory read, sum update, reciprocal multiply and rounding stages.
// Reset clears all control state; the memories need no clearing pass.
// full rises only when the four-entry item queue fills behind a stalled result queue.
`timescale 1ns / 1ps

module temporal_frame_mean_core #(
    parameter int MAX_WINDOW   = 16,
    parameter int MAX_ELEMENTS = 16384
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tfm_pkg::APB_AW-1:0]   paddr,
    input  logic [tfm_pkg::APB_DW-1:0]   pwdata,
    output logic [tfm_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    input  logic                         push,
    output logic                         full,
    input  logic [tfm_pkg::SAMPLE_W-1:0] sample,
    output logic                         empty,
    input  logic                         pop,
    output logic [tfm_pkg::SAMPLE_W-1:0] mean,
    output logic                         frame_end
);

    localparam int POS_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CT_W   = $bits(tfm_pkg::ctrl_t);
    localparam int SW     = tfm_pkg::SAMPLE_W;
    localparam int QW     = SW + POS_W + SLOT_W + CT_W;
    localparam int QDEPTH = 4;

    logic              q_full;
    logic              q_push;
    logic              q_empty;
    logic              q_pop;
    logic [SW-1:0]     f_sample;
    logic [POS_W-1:0]  f_pos;
    logic [SLOT_W-1:0] f_slot;
    tfm_pkg::ctrl_t    f_ctrl;
    logic [QW-1:0]     q_row;
    logic [$clog2(QDEPTH+1)-1:0] q_count;
    logic [SW-1:0]     b_sample;
    logic [POS_W-1:0]  b_pos;
    logic [SLOT_W-1:0] b_slot;
    tfm_pkg::ctrl_t    b_ctrl;
    logic              q_spare;

    tfm_front #(
        .MAX_WINDOW   (MAX_WINDOW),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .push     (push),
        .full     (full),
        .sample   (sample),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_sample (f_sample),
        .q_pos    (f_pos),
        .q_slot   (f_slot),
        .q_ctrl   (f_ctrl)
    );

    tfm_fifo #(
        .WIDTH (QW),
        .DEPTH (QDEPTH)
    ) u_item_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata ({f_sample, f_pos, f_slot, f_ctrl}),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_row),
        .empty (q_empty),
        .count (q_count)
    );

    assign {b_sample, b_pos, b_slot, b_ctrl} = q_row;
    assign q_spare = (q_count == '0) ? q_empty : 1'b0;

    tfm_back #(
        .MAX_WINDOW   (MAX_WINDOW),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty | q_spare),
        .q_pop     (q_pop),
        .q_sample  (b_sample),
        .q_pos     (b_pos),
        .q_slot    (b_slot),
        .q_ctrl    (b_ctrl),
        .empty     (empty),
        .pop       (pop),
        .mean      (mean),
        .frame_end (frame_end)
    );

endmodule

/* hdl/tfm_checker.sv */
// Port-level checker for temporal_frame_mean_core, attached by bind.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module tfm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic [2:0]  paddr,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  mean,
    input logic        frame_end
);

    a_ready_high: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result beat withdrawn before it was taken");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(mean) && $stable(frame_end))
        else $error("waiting result beat changed");

    a_frame_elements_range: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !paddr[2] |-> prdata[14:0] != 15'd0 && prdata[31:15] == 17'd0)
        else $error("frame element count out of range");

    a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
        psel && paddr[2] |-> prdata[4:0] != 5'd0 && prdata[31:5] == 27'd0)
        else $error("window length out of range");

endmodule

bind temporal_frame_mean_core tfm_checker u_tfm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .paddr     (paddr),
    .prdata    (prdata),
    .pready    (pready),
    .empty     (empty),
    .pop       (pop),
    .mean      (mean),
    .frame_end (frame_end)
);
